/* hdl/okvt_pkg.sv */
`timescale 1ns / 1ps

package okvt_pkg;

   localparam int DEFAULT_CAPACITY   = 256;
   localparam int DEFAULT_KEY_BITS   = 32;
   localparam int DEFAULT_VALUE_BITS = 32;
   localparam int KIND_BITS          = 3;
   localparam int RANK_BITS          = 8;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_INSERT         = 3'd0,
      KIND_UPDATE         = 3'd1,
      KIND_INSERT_UPDATE  = 3'd2,
      KIND_ERASE          = 3'd3,
      KIND_KEY_LOOKUP     = 3'd4,
      KIND_RANK_LOOKUP    = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_RANK_LOAD,
      ST_RANK_LATCH,
      ST_RANK_SCAN
   } state_type;

endpackage

/* hdl/ordered_key_value_table.sv */
`timescale 1ns / 1ps
// Insert, update, insert-or-update and key lookup scan the stored entries for the key; erase
// then shifts the entries after the match down; rank lookup rescans all entries per candidate.
// Each scan reads through the single read port of the key/value memory, one entry per cycle.
// Throughput: one operation at a time; start is taken again on the cycle the result shows.
// Reset clears the entry count and the sequencer; the memories are not cleared.
// rsp_valid marks each result for exactly one cycle; the receiver cannot stall.

module ordered_key_value_table
   import okvt_pkg::*;
#(
   parameter int CAPACITY   = DEFAULT_CAPACITY,
   parameter int KEY_BITS   = DEFAULT_KEY_BITS,
   parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [KIND_BITS-1:0]              req_kind,
   input  logic [KEY_BITS-1:0]               req_key,
   input  logic [VALUE_BITS-1:0]             req_value,
   input  logic [RANK_BITS-1:0]              req_rank,
   output logic                              rsp_valid,
   output logic                              rsp_ok,
   output logic [KEY_BITS-1:0]               rsp_found_key,
   output logic [VALUE_BITS-1:0]             rsp_found_value,
   output logic [$clog2(CAPACITY+1)-1:0]     rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (CNT_W > RANK_BITS) ? CNT_W : RANK_BITS;

   // key/value memory
   logic [KEY_BITS-1:0]   key_mem [CAPACITY];
   logic [VALUE_BITS-1:0] val_mem [CAPACITY];
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [VALUE_BITS-1:0] val_rd_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      wr_addr;
   logic                  wr_key_en;
   logic                  wr_val_en;
   logic [KEY_BITS-1:0]   wr_key;
   logic [VALUE_BITS-1:0] wr_val;

   state_type             state_ff, state_in;
   kind_type              op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [RANK_BITS-1:0]  rank_ff, rank_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  pend_ff, pend_in;
   logic [IDX_W-1:0]      pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0]      cand_idx_ff, cand_idx_in;
   logic [KEY_BITS-1:0]   cand_key_ff, cand_key_in;
   logic [VALUE_BITS-1:0] cand_val_ff, cand_val_in;
   logic [CNT_W-1:0]      smaller_ff, smaller_in;

   logic                  rsp_valid_ff;
   logic                  rsp_ok_ff;
   logic [KEY_BITS-1:0]   rsp_found_key_ff;
   logic [VALUE_BITS-1:0] rsp_found_value_ff;
   logic [CNT_W-1:0]      rsp_entry_count_ff;

   logic                  fin;
   logic                  fin_ok;
   logic [KEY_BITS-1:0]   fin_key;
   logic [VALUE_BITS-1:0] fin_val;

   logic                  issue;
   logic                  hit;
   logic                  drained;
   logic                  rank_hit;
   logic                  cand_last;
   logic                  rank_in_range;

   assign issue         = (idx_ff < count_ff);
   assign hit           = pend_ff && (key_rd_ff == key_ff);
   assign drained       = !issue && !pend_ff;
   assign rank_hit      = (CMP_W'(smaller_ff) == CMP_W'(rank_ff));
   assign cand_last     = (CNT_W'(cand_idx_ff + CNT_W'(1)) >= count_ff);
   assign rank_in_range = (CMP_W'(req_rank) < CMP_W'(count_ff));

   always_ff @(posedge clock) begin
      if (wr_key_en) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (wr_val_en) begin
         val_mem[wr_addr] <= wr_val;
      end
      key_rd_ff <= key_mem[rd_addr];
      val_rd_ff <= val_mem[rd_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (kind_type'(req_kind))
                  KIND_INSERT, KIND_UPDATE, KIND_INSERT_UPDATE,
                  KIND_ERASE, KIND_KEY_LOOKUP: state_in = ST_SCAN;
                  KIND_RANK_LOOKUP: state_in = rank_in_range ? ST_RANK_LOAD : ST_IDLE;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = (op_ff == KIND_ERASE) ? ST_SHIFT : ST_IDLE;
            end else if (drained) begin
               state_in = ST_IDLE;
            end
         end
         ST_SHIFT: begin
            if (drained) begin
               state_in = ST_IDLE;
            end
         end
         ST_RANK_LOAD:  state_in = ST_RANK_LATCH;
         ST_RANK_LATCH: state_in = ST_RANK_SCAN;
         ST_RANK_SCAN: begin
            if (drained) begin
               state_in = (rank_hit || cand_last) ? ST_IDLE : ST_RANK_LOAD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in       = op_ff;
      key_in      = key_ff;
      value_in    = value_ff;
      rank_in     = rank_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      cand_idx_in = cand_idx_ff;
      cand_key_in = cand_key_ff;
      cand_val_in = cand_val_ff;
      smaller_in  = smaller_ff;
      rd_addr     = idx_ff[IDX_W-1:0];
      wr_addr     = pend_idx_ff;
      wr_key_en   = 1'b0;
      wr_val_en   = 1'b0;
      wr_key      = key_ff;
      wr_val      = value_ff;
      fin         = 1'b0;
      fin_ok      = 1'b0;
      fin_key     = '0;
      fin_val     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in       = kind_type'(req_kind);
               key_in      = req_key;
               value_in    = req_value;
               rank_in     = req_rank;
               idx_in      = '0;
               cand_idx_in = '0;
               unique case (kind_type'(req_kind))
                  KIND_INSERT, KIND_UPDATE, KIND_INSERT_UPDATE,
                  KIND_ERASE, KIND_KEY_LOOKUP: fin = 1'b0;
                  KIND_RANK_LOOKUP: fin = !rank_in_range;
                  default: fin = 1'b1;
               endcase
            end
         end
         ST_SCAN: begin
            pend_in     = issue;
            pend_idx_in = idx_ff[IDX_W-1:0];
            if (issue) begin
               idx_in = CNT_W'(idx_ff + CNT_W'(1));
            end
            if (hit) begin
               unique case (op_ff)
                  KIND_UPDATE, KIND_INSERT_UPDATE: begin
                     wr_val_en = 1'b1;
                     fin       = 1'b1;
                     fin_ok    = 1'b1;
                  end
                  KIND_ERASE: begin
                     // close the gap from the entry after the match
                     idx_in  = CNT_W'(CNT_W'(pend_idx_ff) + CNT_W'(1));
                     pend_in = 1'b0;
                  end
                  KIND_KEY_LOOKUP: begin
                     fin     = 1'b1;
                     fin_ok  = 1'b1;
                     fin_val = val_rd_ff;
                  end
                  default: fin = 1'b1;
               endcase
            end else if (drained) begin
               fin = 1'b1;
               if ((op_ff == KIND_INSERT || op_ff == KIND_INSERT_UPDATE) &&
                   count_ff < CNT_W'(CAPACITY)) begin
                  wr_addr   = count_ff[IDX_W-1:0];
                  wr_key_en = 1'b1;
                  wr_val_en = 1'b1;
                  count_in  = CNT_W'(count_ff + CNT_W'(1));
                  fin_ok    = 1'b1;
               end
            end
         end
         ST_SHIFT: begin
            pend_in     = issue;
            pend_idx_in = idx_ff[IDX_W-1:0];
            if (issue) begin
               idx_in = CNT_W'(idx_ff + CNT_W'(1));
            end
            if (pend_ff) begin
               wr_addr   = IDX_W'(pend_idx_ff - IDX_W'(1));
               wr_key    = key_rd_ff;
               wr_val    = val_rd_ff;
               wr_key_en = 1'b1;
               wr_val_en = 1'b1;
            end
            if (drained) begin
               count_in = CNT_W'(count_ff - CNT_W'(1));
               fin      = 1'b1;
               fin_ok   = 1'b1;
            end
         end
         ST_RANK_LOAD: begin
            rd_addr = cand_idx_ff[IDX_W-1:0];
         end
         ST_RANK_LATCH: begin
            cand_key_in = key_rd_ff;
            cand_val_in = val_rd_ff;
            idx_in      = '0;
            smaller_in  = '0;
         end
         ST_RANK_SCAN: begin
            pend_in     = issue;
            pend_idx_in = idx_ff[IDX_W-1:0];
            if (issue) begin
               idx_in = CNT_W'(idx_ff + CNT_W'(1));
            end
            if (pend_ff && cand_key_ff > key_rd_ff) begin
               smaller_in = CNT_W'(smaller_ff + CNT_W'(1));
            end
            if (drained) begin
               if (rank_hit) begin
                  fin     = 1'b1;
                  fin_ok  = 1'b1;
                  fin_key = cand_key_ff;
                  fin_val = cand_val_ff;
               end else if (cand_last) begin
                  fin = 1'b1;
               end else begin
                  cand_idx_in = CNT_W'(cand_idx_ff + CNT_W'(1));
               end
            end
         end
         default: fin = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= fin;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      rank_ff     <= rank_in;
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      cand_idx_ff <= cand_idx_in;
      cand_key_ff <= cand_key_in;
      cand_val_ff <= cand_val_in;
      smaller_ff  <= smaller_in;
      if (fin) begin
         rsp_ok_ff          <= fin_ok;
         rsp_found_key_ff   <= fin_key;
         rsp_found_value_ff <= fin_val;
         rsp_entry_count_ff <= count_in;
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_found_key   = rsp_found_key_ff;
   assign rsp_found_value = rsp_found_value_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

   // an accepted beat either starts work or answers at once
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted beat neither started nor answered");

   // the entry count moves only with a result
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |-> rsp_valid_ff)
      else $error("entry count changed without a result");

   // a nonzero found key comes only from a successful rank lookup
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found_key != '0) |-> (rsp_ok && rsp_entry_count != '0))
      else $error("found key reported without success");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= CNT_W'(CAPACITY)))
      else $error("entry count beyond capacity");

endmodule
